// ===== rtl/bgc_pkg.sv =====
// Shared types and constants for the button gesture classifier.
// No dependencies; imported by button_gesture_classifier_unit.
package bgc_pkg;

  localparam int TIME_WIDTH_DEF = 32;

  localparam int CFG_WIDTH     = 16;
  localparam int DEB_WIDTH     = 4;
  localparam int CFG_IDX_WIDTH = 4;
  localparam int NOW_WIDTH     = 32;

  localparam int IN_TDATA_WIDTH  = 40;
  localparam int OUT_TDATA_WIDTH = 8;

  localparam logic [CFG_WIDTH-1:0] SHORT_MIN_RST   = 16'd50;
  localparam logic [CFG_WIDTH-1:0] SHORT_MAX_RST   = 16'd600;
  localparam logic [CFG_WIDTH-1:0] DOUBLE_WIN_RST  = 16'd1000;
  localparam logic [CFG_WIDTH-1:0] LONG_MIN_RST    = 16'd1000;
  localparam logic [CFG_WIDTH-1:0] LONG_MAX_RST    = 16'd3000;
  localparam logic [CFG_WIDTH-1:0] RESET_MAX_RST   = 16'd5000;
  localparam logic [CFG_WIDTH-1:0] HALF_WIN_RST    = 16'd10000;
  localparam logic [DEB_WIDTH-1:0] DEBOUNCE_RST    = 4'd10;
  localparam logic [DEB_WIDTH-1:0] DEBOUNCE_SAT    = 4'd15;

  typedef enum logic [CFG_IDX_WIDTH-1:0] {
    CFG_SHORT_MIN  = 4'd0,
    CFG_SHORT_MAX  = 4'd1,
    CFG_DOUBLE_WIN = 4'd2,
    CFG_LONG_MIN   = 4'd3,
    CFG_LONG_MAX   = 4'd4,
    CFG_RESET_MAX  = 4'd5,
    CFG_HALF_WIN   = 4'd6,
    CFG_DEBOUNCE   = 4'd7
  } cfg_idx_t;

  typedef enum logic [1:0] {
    KIND_NONE   = 2'd0,
    KIND_SHORT  = 2'd1,
    KIND_DOUBLE = 2'd2,
    KIND_LONG   = 2'd3
  } kind_t;

  typedef enum logic [2:0] {
    IND_DEFAULT      = 3'd0,
    IND_RACE         = 3'd1,
    IND_HALF         = 3'd2,
    IND_HALF_PRESSED = 3'd3,
    IND_DANGER       = 3'd4
  } ind_t;

  typedef enum logic [2:0] {
    EV_NONE    = 3'd0,
    EV_PRESS   = 3'd1,
    EV_SHORT   = 3'd2,
    EV_DOUBLE  = 3'd3,
    EV_LONG    = 3'd4,
    EV_FACTORY = 3'd5,
    EV_UNCLASS = 3'd6
  } event_t;

endpackage

// ===== rtl/button_gesture_classifier_unit.sv =====
// Button gesture classifier: debounce, press-duration classification, indicator.
// Depends on bgc_pkg.
//
// One timestamped button sample enters per word on the s_ side and exactly one
// result word leaves per sample on the m_ side, in order. A sample is taken
// every cycle unless the result register is full and m_tready is low; it passes
// the input register, then the result register, and the only loop is the
// classifier state update. A press is accepted after debounce_samples consecutive
// pressed samples (zero acts as one). On release the hold time is classified
// as short, double, long, factory reset (only inside the half-reset window
// after a double press) or unclassified. Elapsed times are wrapping unsigned
// differences over TIME_WIDTH bits. Configuration writes are taken at any
// time and must only be issued while the block is idle; writes to an index
// beyond 7 are ignored.
module button_gesture_classifier_unit
  import bgc_pkg::*;
#(
  parameter int TIME_WIDTH = TIME_WIDTH_DEF
) (
  input  logic                       clk,
  input  logic                       rst,
  input  logic                       s_tvalid,
  output logic                       s_tready,
  // [0] button_pressed, [32:1] now_ms, [33] race_active, [39:34] zero
  input  logic [IN_TDATA_WIDTH-1:0]  s_tdata,
  output logic                       m_tvalid,
  input  logic                       m_tready,
  // [2:0] event_res, [5:3] indicator, [6] race_mode, [7] zero
  output logic [OUT_TDATA_WIDTH-1:0] m_tdata,
  input  logic                       cfg_valid,
  output logic                       cfg_ready,
  input  logic [CFG_IDX_WIDTH-1:0]   cfg_index,
  input  logic [CFG_WIDTH-1:0]       cfg_data
);

  typedef logic [TIME_WIDTH-1:0] time_t;

  // configuration registers
  logic [CFG_WIDTH-1:0] short_min, short_max, double_win, long_min;
  logic [CFG_WIDTH-1:0] long_max, reset_max, half_win;
  logic [DEB_WIDTH-1:0] debounce;

  // input register
  logic                 in_valid;
  logic                 in_pressed;
  logic [NOW_WIDTH-1:0] in_now;
  logic                 in_race;

  // classifier state
  logic                 prev_pressed, prev_pressed_next;
  logic [DEB_WIDTH-1:0] debounce_run, debounce_run_next;
  time_t                press_start, press_start_next;
  kind_t                last_kind, last_kind_next;
  time_t                last_ms, last_ms_next;
  logic                 race_flag, race_flag_next;
  ind_t                 ind_state, ind_state_next;

  // result register
  logic                 out_valid;
  event_t               out_event;
  ind_t                 out_ind;
  logic                 out_race;
  event_t               event_next;

  logic advance;

  assign advance   = in_valid && (!out_valid || m_tready);
  assign s_tready  = !in_valid || advance;
  assign cfg_ready = 1'b1;
  assign m_tvalid  = out_valid;
  assign m_tdata   = {1'b0, out_race, out_ind, out_event};

  // configuration write decode
  always_ff @(posedge clk) begin
    if (rst) begin
      short_min  <= SHORT_MIN_RST;
      short_max  <= SHORT_MAX_RST;
      double_win <= DOUBLE_WIN_RST;
      long_min   <= LONG_MIN_RST;
      long_max   <= LONG_MAX_RST;
      reset_max  <= RESET_MAX_RST;
      half_win   <= HALF_WIN_RST;
      debounce   <= DEBOUNCE_RST;
    end else if (cfg_valid) begin
      unique case (cfg_index)
        CFG_SHORT_MIN:  short_min  <= cfg_data;
        CFG_SHORT_MAX:  short_max  <= cfg_data;
        CFG_DOUBLE_WIN: double_win <= cfg_data;
        CFG_LONG_MIN:   long_min   <= cfg_data;
        CFG_LONG_MAX:   long_max   <= cfg_data;
        CFG_RESET_MAX:  reset_max  <= cfg_data;
        CFG_HALF_WIN:   half_win   <= cfg_data;
        CFG_DEBOUNCE:   debounce   <= cfg_data[DEB_WIDTH-1:0];
        default: ;
      endcase
    end
  end

  // classification of the registered sample
  always_comb begin
    time_t                now;
    time_t                age_last;
    time_t                held;
    time_t                age_final;
    logic [DEB_WIDTH-1:0] need;
    logic [DEB_WIDTH-1:0] run_inc;
    logic                 half;

    now      = TIME_WIDTH'(in_now);
    age_last = now - last_ms;
    held     = now - press_start;
    need     = (debounce == '0) ? DEB_WIDTH'(1) : debounce;
    run_inc  = (debounce_run < DEBOUNCE_SAT) ? debounce_run + DEB_WIDTH'(1) : debounce_run;
    half     = (last_kind == KIND_DOUBLE) && (age_last < TIME_WIDTH'(half_win));

    prev_pressed_next = prev_pressed;
    debounce_run_next = debounce_run;
    press_start_next  = press_start;
    last_kind_next    = last_kind;
    last_ms_next      = last_ms;
    race_flag_next    = race_flag;
    ind_state_next    = half ? IND_HALF : ind_state;
    event_next        = EV_NONE;

    if (in_pressed) begin
      if (!prev_pressed) begin
        if (run_inc >= need) begin
          debounce_run_next = '0;
          prev_pressed_next = 1'b1;
          press_start_next  = now;
          event_next        = EV_PRESS;
          // disarm race mode unless a race is running
          if (race_flag && !in_race) begin
            race_flag_next = 1'b0;
            if (ind_state_next == IND_RACE) ind_state_next = IND_DEFAULT;
          end
        end else begin
          debounce_run_next = run_inc;
        end
      end else begin
        if (half) ind_state_next = IND_HALF_PRESSED;
        if (half && held > TIME_WIDTH'(long_max)) ind_state_next = IND_DANGER;
        if (held > TIME_WIDTH'(reset_max) &&
            ind_state_next inside {IND_HALF, IND_HALF_PRESSED, IND_DANGER})
          ind_state_next = race_flag ? IND_RACE : IND_DEFAULT;
      end
    end else begin
      debounce_run_next = '0;
      if (prev_pressed) begin
        prev_pressed_next = 1'b0;
        if (held > TIME_WIDTH'(short_min) && held < TIME_WIDTH'(short_max)) begin
          if (last_kind == KIND_SHORT && age_last < TIME_WIDTH'(double_win)) begin
            last_kind_next = KIND_DOUBLE;
            event_next     = EV_DOUBLE;
          end else begin
            last_kind_next = KIND_SHORT;
            event_next     = EV_SHORT;
            if (ind_state_next inside {IND_HALF, IND_HALF_PRESSED, IND_DANGER})
              ind_state_next = race_flag ? IND_RACE : IND_DEFAULT;
          end
          last_ms_next = now;
        end else if (held > TIME_WIDTH'(long_min) && held < TIME_WIDTH'(long_max)) begin
          last_kind_next = KIND_LONG;
          last_ms_next   = now;
          event_next     = EV_LONG;
          race_flag_next = 1'b1;
          ind_state_next = IND_RACE;
        end else if (half && held > TIME_WIDTH'(long_max) &&
                     held < TIME_WIDTH'(reset_max)) begin
          // factory reset: back to reset state, configuration kept
          debounce_run_next = '0;
          press_start_next  = '0;
          last_kind_next    = KIND_NONE;
          last_ms_next      = '0;
          race_flag_next    = 1'b0;
          ind_state_next    = IND_DEFAULT;
          event_next        = EV_FACTORY;
        end else begin
          last_kind_next = KIND_NONE;
          last_ms_next   = '0;
          event_next     = EV_UNCLASS;
        end
      end
    end

    // expire the half-reset indicators
    age_final = now - last_ms_next;
    if (ind_state_next inside {IND_HALF, IND_HALF_PRESSED, IND_DANGER} &&
        (last_kind_next == KIND_NONE || age_final > TIME_WIDTH'(half_win)))
      ind_state_next = race_flag_next ? IND_RACE : IND_DEFAULT;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      in_valid     <= 1'b0;
      out_valid    <= 1'b0;
      prev_pressed <= 1'b0;
      debounce_run <= '0;
      press_start  <= '0;
      last_kind    <= KIND_NONE;
      last_ms      <= '0;
      race_flag    <= 1'b0;
      ind_state    <= IND_DEFAULT;
    end else begin
      if (s_tvalid && s_tready) begin
        in_valid   <= 1'b1;
        in_pressed <= s_tdata[0];
        in_now     <= s_tdata[NOW_WIDTH:1];
        in_race    <= s_tdata[NOW_WIDTH+1];
      end else if (advance) begin
        in_valid <= 1'b0;
      end

      if (advance) begin
        out_valid    <= 1'b1;
        out_event    <= event_next;
        out_ind      <= ind_state_next;
        out_race     <= race_flag_next;
        prev_pressed <= prev_pressed_next;
        debounce_run <= debounce_run_next;
        press_start  <= press_start_next;
        last_kind    <= last_kind_next;
        last_ms      <= last_ms_next;
        race_flag    <= race_flag_next;
        ind_state    <= ind_state_next;
      end else if (m_tready) begin
        out_valid <= 1'b0;
      end
    end
  end

  a_race_ind : assert property (@(posedge clk) disable iff (rst)
    ind_state == IND_RACE |-> race_flag)
    else $error("race indicator shown without race flag");

  a_held_run : assert property (@(posedge clk) disable iff (rst)
    prev_pressed |-> debounce_run == '0)
    else $error("debounce run counting while press is held");

  a_factory_clean : assert property (@(posedge clk) disable iff (rst)
    out_valid && out_event == EV_FACTORY |-> out_ind == IND_DEFAULT && !out_race)
    else $error("factory reset result does not show cleared state");

  a_advance_word : assert property (@(posedge clk) disable iff (rst)
    advance |=> out_valid && !prev_pressed == ($past(prev_pressed_next) == 1'b0))
    else $error("result word or press state lost on advance");

endmodule

// ===== test/button_gesture_classifier_unit_tb.sv =====
`timescale 1ns / 100ps
// Self-checking testbench for button_gesture_classifier_unit: directed gestures, then
// random press sequences under several register settings and stall patterns.
// Depends on bgc_pkg and the RTL of button_gesture_classifier_unit only.
module button_gesture_classifier_unit_tb;
  import bgc_pkg::*;

  localparam int STALL_LIMIT = 2000;
  localparam int RACE_PCT    = 30;

  typedef struct packed {
    event_t ev;
    ind_t   ind;
    logic   race;
  } gesture_res_t;

  logic                       clk;
  logic                       rst;
  logic                       s_tvalid;
  logic                       s_tready;
  // [0] button_pressed, [32:1] now_ms, [33] race_active, [39:34] zero
  logic [IN_TDATA_WIDTH-1:0]  s_tdata;
  logic                       m_tvalid;
  logic                       m_tready;
  // [2:0] event_res, [5:3] indicator, [6] race_mode, [7] zero
  logic [OUT_TDATA_WIDTH-1:0] m_tdata;
  logic                       cfg_valid;
  logic                       cfg_ready;
  logic [CFG_IDX_WIDTH-1:0]   cfg_index;
  logic [CFG_WIDTH-1:0]       cfg_data;

  button_gesture_classifier_unit dut (
    .clk       (clk),
    .rst       (rst),
    .s_tvalid  (s_tvalid),
    .s_tready  (s_tready),
    .s_tdata   (s_tdata),
    .m_tvalid  (m_tvalid),
    .m_tready  (m_tready),
    .m_tdata   (m_tdata),
    .cfg_valid (cfg_valid),
    .cfg_ready (cfg_ready),
    .cfg_index (cfg_index),
    .cfg_data  (cfg_data)
  );

  // Register copy and classifier state of the predictor
  logic [CFG_WIDTH-1:0] reg_val [8];
  logic [CFG_WIDTH-1:0] next_regs [8];
  logic                 btn_down;
  logic [3:0]           deb_run;
  logic [31:0]          press_t0;
  kind_t                last_kind;
  logic [31:0]          last_t;
  logic                 race_flag;
  ind_t                 ind_now;

  gesture_res_t gesture_q [$];
  int           mismatches = 0;
  int           items_sent = 0;
  int           src_idle_pct = 0;
  int           sink_idle_pct = 0;
  int           stall_cycles = 0;
  logic [31:0]  clock_ms;

  initial begin
    clk = 1'b0;
    forever #6 clk = ~clk;
  end

  function void clear_gesture_state();
    btn_down  = 1'b0;
    deb_run   = '0;
    press_t0  = '0;
    last_kind = KIND_NONE;
    last_t    = '0;
    race_flag = 1'b0;
    ind_now   = IND_DEFAULT;
  endfunction

  function void release_ind();
    ind_now = race_flag ? IND_RACE : IND_DEFAULT;
  endfunction

  function logic ind_in_half();
    return ind_now >= IND_HALF && ind_now <= IND_DANGER;
  endfunction

  function automatic gesture_res_t classify_sample(input logic pressed,
                                                   input logic [31:0] stamp,
                                                   input logic race_on);
    logic [3:0]   need;
    logic [31:0]  event_age;
    logic [31:0]  held;
    logic         half;
    gesture_res_t res;
    need = (reg_val[CFG_DEBOUNCE][3:0] == '0) ? 4'd1 : reg_val[CFG_DEBOUNCE][3:0];
    res.ev = EV_NONE;
    event_age = stamp - last_t;
    half = (last_kind == KIND_DOUBLE) && (event_age < {16'd0, reg_val[CFG_HALF_WIN]});
    if (half) ind_now = IND_HALF;
    if (pressed) begin
      if (!btn_down) begin
        if (deb_run < DEBOUNCE_SAT) deb_run = deb_run + 4'd1;
        if (deb_run >= need) begin
          deb_run  = '0;
          btn_down = 1'b1;
          press_t0 = stamp;
          res.ev   = EV_PRESS;
          if (race_flag && !race_on) begin
            race_flag = 1'b0;
            if (ind_now == IND_RACE) release_ind();
          end
        end
      end else begin
        held = stamp - press_t0;
        if (half) ind_now = IND_HALF_PRESSED;
        if (half && held > reg_val[CFG_LONG_MAX]) ind_now = IND_DANGER;
        if (held > reg_val[CFG_RESET_MAX] && ind_in_half()) release_ind();
      end
    end else begin
      deb_run = '0;
      if (btn_down) begin
        held = stamp - press_t0;
        btn_down = 1'b0;
        if (held > reg_val[CFG_SHORT_MIN] && held < reg_val[CFG_SHORT_MAX]) begin
          if (last_kind == KIND_SHORT && event_age < reg_val[CFG_DOUBLE_WIN]) begin
            last_kind = KIND_DOUBLE;
            res.ev    = EV_DOUBLE;
          end else begin
            last_kind = KIND_SHORT;
            res.ev    = EV_SHORT;
            if (ind_in_half()) release_ind();
          end
          last_t = stamp;
        end else if (held > reg_val[CFG_LONG_MIN] && held < reg_val[CFG_LONG_MAX]) begin
          last_kind = KIND_LONG;
          last_t    = stamp;
          res.ev    = EV_LONG;
          race_flag = 1'b1;
          ind_now   = IND_RACE;
        end else if (half && held > reg_val[CFG_LONG_MAX]
                     && held < reg_val[CFG_RESET_MAX]) begin
          // factory reset: state back to power-on, registers kept
          clear_gesture_state();
          res.ev   = EV_FACTORY;
          res.ind  = ind_now;
          res.race = race_flag;
          return res;
        end else begin
          last_kind = KIND_NONE;
          last_t    = '0;
          res.ev    = EV_UNCLASS;
        end
      end
    end
    if (ind_in_half() && (last_kind == KIND_NONE
                          || (stamp - last_t) > {16'd0, reg_val[CFG_HALF_WIN]}))
      release_ind();
    res.ind  = ind_now;
    res.race = race_flag;
    return res;
  endfunction

  function automatic logic coin(input int pct);
    return $urandom_range(0, 99) < pct;
  endfunction

  function automatic int unsigned between(input int lo, input int hi);
    if (hi < lo) hi = lo;
    return $urandom_range(lo, hi);
  endfunction

  // Called just after a falling edge; returns just after the falling edge that follows
  // the handshake, leaving s_tvalid high so back-to-back words need no second assignment.
  task automatic send_sample(input logic pressed, input logic [31:0] stamp,
                             input logic race_on);
    while (coin(src_idle_pct)) begin
      s_tvalid <= 1'b0;
      @(negedge clk);
    end
    s_tvalid <= 1'b1;
    s_tdata  <= {{(IN_TDATA_WIDTH - 34){1'b0}}, race_on, stamp, pressed};
    do @(posedge clk); while (!s_tready);
    gesture_q.push_back(classify_sample(pressed, stamp, race_on));
    items_sent++;
    @(negedge clk);
  endtask

  task automatic wait_idle();
    s_tvalid <= 1'b0;
    @(negedge clk);
    while (gesture_q.size() != 0) @(negedge clk);
    repeat (4) @(negedge clk);
  endtask

  // Write next_regs to all eight registers, then poke one unused index
  task automatic program_regs();
    int i;
    for (i = 0; i <= int'(CFG_DEBOUNCE) + 1; i++) begin
      cfg_valid <= 1'b1;
      if (i > int'(CFG_DEBOUNCE)) begin
        cfg_index <= CFG_IDX_WIDTH'($urandom_range(int'(CFG_DEBOUNCE) + 1,
                                                   (1 << CFG_IDX_WIDTH) - 1));
        cfg_data  <= CFG_WIDTH'($urandom());
      end else begin
        cfg_index <= CFG_IDX_WIDTH'(i);
        cfg_data  <= next_regs[i];
      end
      do @(posedge clk); while (!cfg_ready);
      if (cfg_index <= CFG_DEBOUNCE)
        reg_val[cfg_index] = (cfg_index == CFG_DEBOUNCE) ?
                             {12'd0, cfg_data[3:0]} : cfg_data;
      @(negedge clk);
    end
    cfg_valid <= 1'b0;
    @(negedge clk);
  endtask

  task automatic let_time_pass(input int unsigned gap);
    int n;
    int j;
    n = $urandom_range(1, 3);
    for (j = 0; j < n; j++) begin
      clock_ms = clock_ms + ((j == n - 1) ? gap - (gap / n) * (n - 1) : gap / n);
      send_sample(1'b0, clock_ms, coin(RACE_PCT));
    end
  endtask

  // Bounce, debounce run, up to three held samples spread over the hold, release, gap
  task automatic run_gesture(input int unsigned hold, input int unsigned gap);
    int          need;
    int          k;
    int          j;
    logic [31:0] t0;
    need = (reg_val[CFG_DEBOUNCE] == 0) ? 1 : int'(reg_val[CFG_DEBOUNCE]);
    if (need > 1)
      repeat ($urandom_range(0, 2)) begin
        repeat ($urandom_range(1, need - 1)) begin
          clock_ms++;
          send_sample(1'b1, clock_ms, coin(RACE_PCT));
        end
        clock_ms++;
        send_sample(1'b0, clock_ms, coin(RACE_PCT));
      end
    repeat (need) begin
      clock_ms++;
      send_sample(1'b1, clock_ms, coin(RACE_PCT));
    end
    t0 = clock_ms;
    k = $urandom_range(0, 3);
    for (j = 1; j <= k; j++)
      send_sample(1'b1, t0 + (hold / (k + 1)) * j, coin(RACE_PCT));
    clock_ms = t0 + hold;
    send_sample(1'b0, clock_ms, coin(RACE_PCT));
    let_time_pass(gap);
  endtask

  function automatic int unsigned short_hold();
    return between(int'(reg_val[CFG_SHORT_MIN]) + 1, int'(reg_val[CFG_SHORT_MAX]) - 1);
  endfunction

  function automatic int unsigned reset_hold();
    return between(int'(reg_val[CFG_LONG_MAX]) + 1, int'(reg_val[CFG_RESET_MAX]) - 1);
  endfunction

  function automatic int unsigned pick_hold();
    case ($urandom_range(0, 9))
      3: return between(int'(reg_val[CFG_LONG_MIN]) + 1, int'(reg_val[CFG_LONG_MAX]) - 1);
      4: return reset_hold();
      5: begin
        case ($urandom_range(0, 4))
          0: return reg_val[CFG_SHORT_MIN];
          1: return reg_val[CFG_SHORT_MAX];
          2: return reg_val[CFG_LONG_MIN];
          3: return reg_val[CFG_LONG_MAX];
          default: return reg_val[CFG_RESET_MAX];
        endcase
      end
      6: return between(0, 2 * int'(reg_val[CFG_RESET_MAX]) + 10);
      default: return short_hold();
    endcase
  endfunction

  function automatic int unsigned pick_gap();
    case ($urandom_range(0, 9))
      7, 8: return between(0, int'(reg_val[CFG_HALF_WIN]) + 2000);
      9: return $urandom();
      default: return between(0, 1500);
    endcase
  endfunction

  task automatic run_random_phase(input int count);
    int target;
    target = items_sent + count;
    while (items_sent < target) begin
      case ($urandom_range(0, 9))
        5, 6, 7: begin
          // short, quick second short, then most often a reset-length hold
          run_gesture(short_hold(), between(0, int'(reg_val[CFG_DOUBLE_WIN]) / 4));
          run_gesture(short_hold(), between(0, 300));
          run_gesture(coin(65) ? reset_hold() : pick_hold(), pick_gap());
        end
        8: begin
          repeat ($urandom_range(1, 6)) begin
            clock_ms = $urandom();
            send_sample(coin(50), clock_ms, coin(50));
          end
        end
        9: run_gesture(between(int'(reg_val[CFG_LONG_MIN]) + 1,
                               int'(reg_val[CFG_LONG_MAX]) - 1), pick_gap());
        default: run_gesture(pick_hold(), pick_gap());
      endcase
    end
    wait_idle();
  endtask

  function void load_reset_values();
    next_regs[CFG_SHORT_MIN]  = SHORT_MIN_RST;
    next_regs[CFG_SHORT_MAX]  = SHORT_MAX_RST;
    next_regs[CFG_DOUBLE_WIN] = DOUBLE_WIN_RST;
    next_regs[CFG_LONG_MIN]   = LONG_MIN_RST;
    next_regs[CFG_LONG_MAX]   = LONG_MAX_RST;
    next_regs[CFG_RESET_MAX]  = RESET_MAX_RST;
    next_regs[CFG_HALF_WIN]   = HALF_WIN_RST;
    next_regs[CFG_DEBOUNCE]   = {12'd0, DEBOUNCE_RST};
  endfunction

  // Every event kind, the indicator walk through half reset, and time wrap
  task automatic test_directed();
    src_idle_pct  = 24;
    sink_idle_pct = 87;
    load_reset_values();
    next_regs[CFG_DEBOUNCE] = 16'd1;
    program_regs();
    send_sample(1'b1, 32'd0, 1'b0);
    send_sample(1'b0, 32'd100, 1'b0);       // short
    send_sample(1'b1, 32'd300, 1'b0);
    send_sample(1'b0, 32'd400, 1'b0);       // double, half reset opens
    send_sample(1'b1, 32'd1000, 1'b0);
    send_sample(1'b1, 32'd3000, 1'b0);
    send_sample(1'b1, 32'd4500, 1'b0);      // danger
    send_sample(1'b0, 32'd5000, 1'b0);      // factory reset
    send_sample(1'b1, 32'd6000, 1'b0);
    send_sample(1'b0, 32'd8000, 1'b0);      // long, race mode on
    send_sample(1'b1, 32'd8100, 1'b1);      // race running: flag kept
    send_sample(1'b0, 32'd8101, 1'b1);      // too brief
    send_sample(1'b1, 32'd9000, 1'b0);      // disarm
    send_sample(1'b0, 32'hFFFF_FFFF, 1'b1);
    send_sample(1'b1, 32'hFFFF_FFF0, 1'b1);
    send_sample(1'b0, 32'h0000_0050, 1'b0); // short across the wrap
    send_sample(1'b1, 32'h0000_0100, 1'b1);
    send_sample(1'b0, 32'h0000_0180, 1'b0); // double
    send_sample(1'b1, 32'h0000_0200, 1'b0);
    send_sample(1'b1, 32'h0000_0200 + 32'd6000, 1'b0); // held past abandon time
    send_sample(1'b0, 32'h0000_0200 + 32'd6100, 1'b0);
    wait_idle();
  endtask

  task automatic test_gestures_default();
    src_idle_pct  = 24;
    sink_idle_pct = 87;
    load_reset_values();
    program_regs();
    clock_ms = 32'hFFFF_FFFF - $urandom_range(0, 50000);
    run_random_phase(200);
  endtask

  task automatic test_gestures_scaled();
    src_idle_pct  = 87;
    sink_idle_pct = 24;
    next_regs[CFG_SHORT_MIN]  = 16'($urandom_range(0, 200));
    next_regs[CFG_SHORT_MAX]  = next_regs[CFG_SHORT_MIN] + 16'($urandom_range(100, 900));
    next_regs[CFG_DOUBLE_WIN] = 16'($urandom_range(200, 3000));
    next_regs[CFG_LONG_MIN]   = next_regs[CFG_SHORT_MAX] + 16'($urandom_range(0, 500));
    next_regs[CFG_LONG_MAX]   = next_regs[CFG_LONG_MIN] + 16'($urandom_range(500, 4000));
    next_regs[CFG_RESET_MAX]  = next_regs[CFG_LONG_MAX] + 16'($urandom_range(500, 4000));
    next_regs[CFG_HALF_WIN]   = 16'($urandom_range(2000, 20000));
    // upper bits are dropped by the register
    next_regs[CFG_DEBOUNCE]   = 16'($urandom_range(1, 15) | ($urandom_range(0, 4095) << 4));
    program_regs();
    clock_ms = $urandom();
    run_random_phase(200);
  endtask

  task automatic test_config_extremes();
    int i;
    src_idle_pct  = 0;
    sink_idle_pct = 0;
    // all zero: debounce of zero behaves as one
    for (i = 0; i <= int'(CFG_DEBOUNCE); i++) next_regs[i] = '0;
    program_regs();
    run_random_phase(60);
    for (i = 0; i <= int'(CFG_DEBOUNCE); i++) next_regs[i] = '1;
    program_regs();
    run_random_phase(60);
    // widest windows: every sane hold is short or double, half reset lasts long
    next_regs[CFG_SHORT_MIN]  = '0;
    next_regs[CFG_SHORT_MAX]  = '1;
    next_regs[CFG_DOUBLE_WIN] = '1;
    next_regs[CFG_LONG_MIN]   = '0;
    next_regs[CFG_LONG_MAX]   = 16'd1;
    next_regs[CFG_RESET_MAX]  = '1;
    next_regs[CFG_HALF_WIN]   = '1;
    next_regs[CFG_DEBOUNCE]   = 16'd1;
    program_regs();
    run_random_phase(80);
  endtask

  always @(negedge clk) m_tready <= ($urandom_range(0, 99) >= sink_idle_pct);

  always @(posedge clk) begin : check_results
    gesture_res_t want;
    if (!rst && m_tvalid && m_tready) begin
      if (gesture_q.size() == 0) begin
        $display("%0t: unexpected result word, expected none, actual %h", $time, m_tdata);
        mismatches++;
      end else begin
        want = gesture_q.pop_front();
        if (m_tdata[2:0] !== want.ev) begin
          $display("%0t: event expected %0d actual %0d", $time, want.ev, m_tdata[2:0]);
          mismatches++;
        end
        if (m_tdata[5:3] !== want.ind) begin
          $display("%0t: indicator expected %0d actual %0d", $time, want.ind, m_tdata[5:3]);
          mismatches++;
        end
        if (m_tdata[6] !== want.race) begin
          $display("%0t: race mode expected %0d actual %0d", $time, want.race, m_tdata[6]);
          mismatches++;
        end
      end
    end
  end

  // Count cycles in which no word moves on any channel
  always @(posedge clk) begin
    if (rst || (s_tvalid && s_tready) || (m_tvalid && m_tready) || (cfg_valid && cfg_ready))
      stall_cycles <= 0;
    else
      stall_cycles <= stall_cycles + 1;
    if (stall_cycles == STALL_LIMIT) begin
      $display("[button_gesture_classifier_unit] ERROR");
      $finish;
    end
  end

  initial begin
    rst       = 1'b1;
    s_tvalid  = 1'b0;
    s_tdata   = '0;
    cfg_valid = 1'b0;
    cfg_index = '0;
    cfg_data  = '0;
    clock_ms  = '0;
    reg_val[CFG_SHORT_MIN]  = SHORT_MIN_RST;
    reg_val[CFG_SHORT_MAX]  = SHORT_MAX_RST;
    reg_val[CFG_DOUBLE_WIN] = DOUBLE_WIN_RST;
    reg_val[CFG_LONG_MIN]   = LONG_MIN_RST;
    reg_val[CFG_LONG_MAX]   = LONG_MAX_RST;
    reg_val[CFG_RESET_MAX]  = RESET_MAX_RST;
    reg_val[CFG_HALF_WIN]   = HALF_WIN_RST;
    reg_val[CFG_DEBOUNCE]   = {12'd0, DEBOUNCE_RST};
    clear_gesture_state();
    repeat (5) @(posedge clk);
    @(negedge clk);
    rst <= 1'b0;
    test_directed();
    test_gestures_default();
    test_gestures_scaled();
    test_config_extremes();
    repeat (8) @(negedge clk);
    if (mismatches == 0 && gesture_q.size() == 0)
      $display("[button_gesture_classifier_unit] OK");
    else
      $display("[button_gesture_classifier_unit] ERROR");
    $finish;
  end

endmodule

// ===== files.f =====
rtl/bgc_pkg.sv
rtl/button_gesture_classifier_unit.sv
test/button_gesture_classifier_unit_tb.sv
